// File: rtl/lfr_pkg.sv
`default_nettype none

package lfr_pkg;

  // Default number of frame cells in the recency row.
  localparam int DEF_MAX_FRAMES = 64;

  // Field widths fixed by the interface.
  localparam int FRAME_W = 6;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;

  // Frames managed after reset.
  localparam logic [CNT_W-1:0] FRAMES_RESET = 7'd64;

  // Request commands.
  localparam logic CMD_REF   = 1'b0;
  localparam logic CMD_EVICT = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // Update actions chosen during lookup.
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_MOVE   = 2'd2;
  localparam logic [1:0] ACT_EVICT  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic lookup;
    logic update;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_update;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/lfr_ctrl.sv
`default_nettype none

module lfr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire lfr_pkg::dp_sts_t   sts,
  output lfr_pkg::ctrl_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  // The result register can be loaded when empty or being taken this cycle.
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer: accept, look up the cell row, update it when needed, deliver the result.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = sts.needs_update ? ST_UPDATE : ST_FINISH;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid holds until the result is taken.
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result register loaded while a result is still pending");

endmodule

`default_nettype wire

// File: rtl/lfr_dpath.sv
`default_nettype none

module lfr_dpath #(
  parameter int MAX_FRAMES = lfr_pkg::DEF_MAX_FRAMES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lfr_pkg::ctrl_cmd_t          cmd,
  output lfr_pkg::dp_sts_t                 sts,
  input  wire logic                        cfg_we,
  input  wire logic [lfr_pkg::CNT_W-1:0]   cfg_data,
  input  wire logic                        in_command,
  input  wire logic [lfr_pkg::FRAME_W-1:0] in_frame_index,
  output logic [lfr_pkg::FRAME_W-1:0]      out_evicted_frame,
  output logic [lfr_pkg::STAT_W-1:0]       out_status,
  output logic [lfr_pkg::CNT_W-1:0]        out_tracked_count
);

  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int LEN_W = $clog2(MAX_FRAMES + 1);
  localparam int FW    = lfr_pkg::FRAME_W;
  localparam int CW    = lfr_pkg::CNT_W;

  // Configuration and order length.
  logic [CW-1:0]         frames_r;
  logic [LEN_W-1:0]      len_r;
  logic [LEN_W-1:0]      len_nxt;

  // Cell row: one tracked mark and one recency rank per frame.
  logic [MAX_FRAMES-1:0] tracked_r;
  logic [MAX_FRAMES-1:0] tracked_nxt;
  logic [IDX_W-1:0]      rank_r   [MAX_FRAMES];
  logic [IDX_W-1:0]      rank_nxt [MAX_FRAMES];

  // Request and lookup registers.
  logic                  req_cmd_r;
  logic [FW-1:0]         req_frame_r;
  logic [IDX_W+FW-1:0]   frame_wide;
  logic [IDX_W-1:0]      req_idx;
  logic [1:0]            action_r;
  logic [1:0]            action_nxt;
  logic [lfr_pkg::STAT_W-1:0] stat_r;
  logic [lfr_pkg::STAT_W-1:0] stat_nxt;
  logic [IDX_W-1:0]      thresh_r;
  logic [IDX_W-1:0]      thresh_nxt;
  logic [MAX_FRAMES-1:0] lru_hot_r;
  logic [MAX_FRAMES-1:0] lru_hot_nxt;
  logic                  in_range;
  logic                  sel_tracked;
  logic [IDX_W-1:0]      sel_rank;

  // Eviction index and result fields.
  logic [IDX_W-1:0]      ev_idx;
  logic [IDX_W+FW-1:0]   ev_wide;
  logic [LEN_W+CW-1:0]   len_wide;
  logic [FW-1:0]         out_evicted_r;
  logic [lfr_pkg::STAT_W-1:0] out_status_r;
  logic [CW-1:0]         out_count_r;

  assign frame_wide = {{IDX_W{1'b0}}, req_frame_r};
  assign req_idx    = frame_wide[IDX_W-1:0];

  // Lookup: each cell checks itself against the requested frame and rank zero.
  always_comb begin
    in_range    = ({1'b0, req_frame_r} < frames_r) && (32'(req_frame_r) < MAX_FRAMES);
    sel_tracked = 1'b0;
    sel_rank    = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (req_idx == IDX_W'(i)) begin
        sel_tracked = sel_tracked | tracked_r[i];
        sel_rank    = sel_rank | rank_r[i];
      end
      lru_hot_nxt[i] = tracked_r[i] && (rank_r[i] == '0);
    end
    action_nxt = lfr_pkg::ACT_NONE;
    stat_nxt   = lfr_pkg::STAT_OK;
    thresh_nxt = '0;
    priority if (req_cmd_r == lfr_pkg::CMD_EVICT) begin
      if (len_r == '0) begin
        stat_nxt = lfr_pkg::STAT_EMPTY;
      end else begin
        action_nxt = lfr_pkg::ACT_EVICT;
      end
    end else if (!in_range) begin
      stat_nxt = lfr_pkg::STAT_RANGE;
    end else if (sel_tracked) begin
      action_nxt = lfr_pkg::ACT_MOVE;
      thresh_nxt = sel_rank;
    end else if (len_r < LEN_W'(MAX_FRAMES)) begin
      action_nxt = lfr_pkg::ACT_APPEND;
    end else begin
      action_nxt = lfr_pkg::ACT_NONE;
    end
  end

  assign sts.needs_update = (action_nxt != lfr_pkg::ACT_NONE);

  // Encode the least recent cell from its one-hot marker.
  always_comb begin
    ev_idx = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      ev_idx = ev_idx | (lru_hot_r[i] ? IDX_W'(i) : '0);
    end
  end

  // Update: on a move or evict, cells above the threshold move one step toward least recent.
  always_comb begin
    tracked_nxt = tracked_r;
    len_nxt     = len_r;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (cmd.update) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if ((action_r == lfr_pkg::ACT_MOVE || action_r == lfr_pkg::ACT_EVICT) &&
            tracked_r[i] && (rank_r[i] > thresh_r)) begin
          rank_nxt[i] = rank_r[i] - 1'b1;
        end
        if (req_idx == IDX_W'(i)) begin
          if (action_r == lfr_pkg::ACT_MOVE) begin
            rank_nxt[i] = IDX_W'(len_r - 1'b1);
          end
          if (action_r == lfr_pkg::ACT_APPEND) begin
            tracked_nxt[i] = 1'b1;
            rank_nxt[i]    = IDX_W'(len_r);
          end
        end
        if (action_r == lfr_pkg::ACT_EVICT && lru_hot_r[i]) begin
          tracked_nxt[i] = 1'b0;
        end
      end
      if (action_r == lfr_pkg::ACT_APPEND) begin
        len_nxt = len_r + 1'b1;
      end else if (action_r == lfr_pkg::ACT_EVICT) begin
        len_nxt = len_r - 1'b1;
      end
    end
  end

  // Control state: marks, length and the frame limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r <= '0;
      len_r     <= '0;
      frames_r  <= lfr_pkg::FRAMES_RESET;
    end else begin
      tracked_r <= tracked_nxt;
      len_r     <= len_nxt;
      if (cfg_we) begin
        frames_r <= cfg_data;
      end
    end
  end

  // Ranks are meaningful only where the cell is tracked.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_r[i] <= rank_nxt[i];
    end
  end

  // Request and lookup capture.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_cmd_r   <= in_command;
      req_frame_r <= in_frame_index;
    end
    if (cmd.lookup) begin
      action_r  <= action_nxt;
      stat_r    <= stat_nxt;
      thresh_r  <= thresh_nxt;
      lru_hot_r <= lru_hot_nxt;
    end
  end

  // Result register.
  assign ev_wide  = {{FW{1'b0}}, ev_idx};
  assign len_wide = {{CW{1'b0}}, len_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_evicted_r <= (action_r == lfr_pkg::ACT_EVICT) ? ev_wide[FW-1:0] : '0;
      out_status_r  <= stat_r;
      out_count_r   <= len_wide[CW-1:0];
    end
  end

  assign out_evicted_frame = out_evicted_r;
  assign out_status        = out_status_r;
  assign out_tracked_count = out_count_r;

  // The number of tracked marks always equals the order length.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tracked_r) == int'(len_r))
    else $error("tracked marks disagree with order length");

  // An eviction finds exactly one least recent cell.
  a_single_lru: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && action_r == lfr_pkg::ACT_EVICT) |-> $onehot(lru_hot_r))
    else $error("eviction without a unique least recent cell");

  // The order never grows past the cell count.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(len_r) <= MAX_FRAMES)
    else $error("order length exceeds frame cells");

endmodule

`default_nettype wire

// File: rtl/lru_frame_replacement.sv
`default_nettype none

// Exact least-recently-used replacement over physical page frames. A reference
// request (command 0) marks a frame as most recent, adding it if untracked; an
// evict request (command 1) removes and returns the least recent frame. Status
// reports an evict with nothing tracked or a frame at or above frames_in_use;
// in both cases state is left unchanged. Each frame has a cell holding its
// tracked mark and its recency rank, and all cells compare and shift ranks in
// parallel. A request passes through accept, lookup, update and result load,
// skipping update when it changes no state, in the controller's sequence over
// the shared cell row; one request is in work at a time, and a new one can be
// accepted while the previous result waits on out_stall. Marks clear at reset
// with no clearing pass. frames_in_use is written through the cfg port,
// which is always ready, and should only change while the block is idle.
module lru_frame_replacement #(
  parameter int MAX_FRAMES = lfr_pkg::DEF_MAX_FRAMES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_command,
  input  wire logic [lfr_pkg::FRAME_W-1:0] in_frame_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lfr_pkg::FRAME_W-1:0]      out_evicted_frame,
  output logic [lfr_pkg::STAT_W-1:0]       out_status,
  output logic [lfr_pkg::CNT_W-1:0]        out_tracked_count,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lfr_pkg::CNT_W-1:0]   cfg_frames_in_use
);

  lfr_pkg::ctrl_cmd_t cmd;
  lfr_pkg::dp_sts_t   sts;

  // The frame limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  lfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfr_dpath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_frames_in_use),
    .in_command        (in_command),
    .in_frame_index    (in_frame_index),
    .out_evicted_frame (out_evicted_frame),
    .out_status        (out_status),
    .out_tracked_count (out_tracked_count)
  );

endmodule

`default_nettype wire
